// ===== design/prl_pkg.sv =====
package prl_pkg;

  // Field widths
  localparam int unsigned CountW  = 8;
  localparam int unsigned TimeW   = 48;
  localparam int unsigned DlW     = TimeW + 1;
  localparam int unsigned DelayW  = 32;
  localparam int unsigned CfgIdxW = 2;

  // Count limits and tier boundaries
  localparam logic [CountW-1:0] CountSat     = 8'd255;
  localparam logic [CountW-1:0] MaxAttMin    = 8'd4;
  localparam logic [CountW-1:0] MaxAttRst    = 8'd21;
  localparam logic [CountW-1:0] Tier0Last    = 8'd3;
  localparam logic [CountW-1:0] Tier1Last    = 8'd6;
  localparam logic [CountW-1:0] Tier2Last    = 8'd9;

  // Delay values; all ones is kept for the bricked answer
  localparam logic [DelayW-1:0] DelayAllOnes = 32'hFFFF_FFFF;
  localparam logic [DelayW-1:0] DelayMax     = 32'hFFFF_FFFE;
  localparam logic [DelayW-1:0] Tier1Rst     = 32'd15000;
  localparam logic [DelayW-1:0] Tier2Rst     = 32'd60000;
  localparam logic [DelayW-1:0] Tier3Rst     = 32'd900000;

  typedef enum logic [1:0] {
    REQ_CHECK   = 2'd0,
    REQ_SUCCESS = 2'd1,
    REQ_FAILURE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    STATUS_ALLOWED = 2'd0,
    STATUS_WAIT    = 2'd1,
    STATUS_BRICKED = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_ATTEMPTS = 2'd0,
    CFG_DELAY_TIER1  = 2'd1,
    CFG_DELAY_TIER2  = 2'd2,
    CFG_DELAY_TIER3  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CountW-1:0] max_attempts;
    logic [DelayW-1:0] tier1;
    logic [DelayW-1:0] tier2;
    logic [DelayW-1:0] tier3;
  } cfg_t;

  typedef struct packed {
    logic [CountW-1:0] fail_count;
    logic [DlW-1:0]    deadline;
    logic              bricked;
  } lock_state_t;

  typedef struct packed {
    status_e           status;
    logic [CountW-1:0] count;
    logic [DelayW-1:0] remaining;
    logic              bricked;
    logic              wipe;
  } result_t;

endpackage

// ===== design/prl_update.sv =====
// Next lockout state and result for one request
module prl_update (
  input  prl_pkg::cfg_t                      cfg_i,
  input  prl_pkg::lock_state_t               state_i,
  input  logic [1:0]                         req_i,
  input  logic [prl_pkg::TimeW-1:0]          now_i,
  output prl_pkg::lock_state_t               state_o,
  output prl_pkg::result_t                   result_o
);

  logic [prl_pkg::CountW-1:0] cnt_inc;
  logic [prl_pkg::DelayW-1:0] tier_delay;
  logic [prl_pkg::DlW-1:0]    now_ext;
  logic [prl_pkg::DlW-1:0]    diff;
  logic                       old_pending;
  logic [prl_pkg::DelayW-1:0] old_rem;
  logic                       new_lock;
  logic                       hit_max;
  logic                       pending;
  logic [prl_pkg::DelayW-1:0] rem;
  logic                       bricked;

  assign now_ext = {1'b0, now_i};

  // Saturating failure count and tier lookup on the raised count
  assign cnt_inc = (state_i.fail_count < prl_pkg::CountSat) ?
                   state_i.fail_count + 8'd1 : state_i.fail_count;
  assign hit_max = (cnt_inc >= cfg_i.max_attempts);

  always_comb begin
    if (cnt_inc <= prl_pkg::Tier0Last) begin
      tier_delay = '0;
    end else if (cnt_inc <= prl_pkg::Tier1Last) begin
      tier_delay = cfg_i.tier1;
    end else if (cnt_inc <= prl_pkg::Tier2Last) begin
      tier_delay = cfg_i.tier2;
    end else begin
      tier_delay = cfg_i.tier3;
    end
  end

  // Time left on the stored deadline
  assign diff        = state_i.deadline - now_ext;
  assign old_pending = (state_i.deadline != '0) && (now_ext < state_i.deadline);
  assign old_rem     = (diff > {17'd0, prl_pkg::DelayMax}) ? prl_pkg::DelayMax :
                       diff[prl_pkg::DelayW-1:0];

  // State update
  always_comb begin
    state_o  = state_i;
    new_lock = 1'b0;
    case (req_i)
      prl_pkg::REQ_SUCCESS: begin
        state_o.fail_count = '0;
        state_o.deadline   = '0;
      end
      prl_pkg::REQ_FAILURE: begin
        state_o.fail_count = cnt_inc;
        if (hit_max) begin
          state_o.bricked = 1'b1;
        end else begin
          new_lock         = 1'b1;
          state_o.deadline = (tier_delay != '0) ?
                             now_ext + {17'd0, tier_delay} : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Fresh lockout: the tier delay; success: none; else stored
  always_comb begin
    if (new_lock) begin
      pending = (tier_delay != '0);
      rem     = tier_delay;
    end else if (req_i == prl_pkg::REQ_SUCCESS) begin
      pending = 1'b0;
      rem     = '0;
    end else begin
      pending = old_pending;
      rem     = old_rem;
    end
  end

  assign bricked = state_o.bricked || (state_o.fail_count >= cfg_i.max_attempts);

  // Result after the update
  always_comb begin
    result_o.count   = state_o.fail_count;
    result_o.bricked = bricked;
    result_o.wipe    = (req_i == prl_pkg::REQ_FAILURE) && hit_max;
    if (bricked) begin
      result_o.status    = prl_pkg::STATUS_BRICKED;
      result_o.remaining = prl_pkg::DelayAllOnes;
    end else if (pending) begin
      result_o.status    = prl_pkg::STATUS_WAIT;
      result_o.remaining = rem;
    end else begin
      result_o.status    = prl_pkg::STATUS_ALLOWED;
      result_o.remaining = '0;
    end
  end

endmodule

// ===== design/pin_retry_lockout_limiter.sv =====
// PIN retry limiter with escalating lockout. Each request (check, success or
// failure, stamped with a 48-bit millisecond time) yields one result: status,
// failure count, milliseconds of lockout left and the bricked and wipe flags,
// all taken after the request's update. The block takes one request per
// cycle while the output is not stalled; a request passes an input register,
// then the state update and the result are computed combinationally into the
// output register, from which the result leaves once out_ready_i is high. The
// failure count, deadline and bricked flag are read and written in that same
// update step, which lets each request follow the last without a bubble.
// Configuration writes through cfg_we_i take effect at once and are meant for
// an idle block.
module pin_retry_lockout_limiter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [prl_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [prl_pkg::DelayW-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        req_type_i,
  input  logic [prl_pkg::TimeW-1:0]         now_ms_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic [prl_pkg::CountW-1:0]        attempt_count_o,
  output logic [prl_pkg::DelayW-1:0]        delay_remaining_ms_o,
  output logic                              is_bricked_o,
  output logic                              wipe_pulse_o
);

  prl_pkg::cfg_t        cfg_q;
  prl_pkg::lock_state_t state_q, state_d;
  prl_pkg::result_t     result_d, result_q;

  logic                      in_vld_q;
  logic [1:0]                req_q;
  logic [prl_pkg::TimeW-1:0] now_q;
  logic                      out_vld_q;
  logic                      advance;

  // Pipeline moves when the output slot is free or being taken
  assign advance    = !out_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || advance;

  // Configuration registers with clamping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_attempts <= prl_pkg::MaxAttRst;
      cfg_q.tier1        <= prl_pkg::Tier1Rst;
      cfg_q.tier2        <= prl_pkg::Tier2Rst;
      cfg_q.tier3        <= prl_pkg::Tier3Rst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        prl_pkg::CFG_MAX_ATTEMPTS: begin
          cfg_q.max_attempts <= (cfg_wdata_i[7:0] < prl_pkg::MaxAttMin) ?
                                prl_pkg::MaxAttMin : cfg_wdata_i[7:0];
        end
        prl_pkg::CFG_DELAY_TIER1: begin
          cfg_q.tier1 <= (cfg_wdata_i == prl_pkg::DelayAllOnes) ?
                         prl_pkg::DelayMax : cfg_wdata_i;
        end
        prl_pkg::CFG_DELAY_TIER2: begin
          cfg_q.tier2 <= (cfg_wdata_i == prl_pkg::DelayAllOnes) ?
                         prl_pkg::DelayMax : cfg_wdata_i;
        end
        default: begin
          cfg_q.tier3 <= (cfg_wdata_i == prl_pkg::DelayAllOnes) ?
                         prl_pkg::DelayMax : cfg_wdata_i;
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= req_type_i;
      now_q <= now_ms_i;
    end
  end

  prl_update u_update (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .req_i    (req_q),
    .now_i    (now_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Lockout state, updated as a request moves into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
      if (in_vld_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o          = out_vld_q;
  assign status_o             = result_q.status;
  assign attempt_count_o      = result_q.count;
  assign delay_remaining_ms_o = result_q.remaining;
  assign is_bricked_o         = result_q.bricked;
  assign wipe_pulse_o         = result_q.wipe;

endmodule

// ===== design/prl_checker.sv =====
// Port-level checks for the retry limiter
module prl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [1:0]                    status_o,
  input logic [prl_pkg::DelayW-1:0]    delay_remaining_ms_o,
  input logic                          is_bricked_o,
  input logic                          wipe_pulse_o
);

  // A pending result stays until transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  // A wipe always comes with a bricked answer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && wipe_pulse_o |->
      is_bricked_o && (status_o == prl_pkg::STATUS_BRICKED))
    else $error("wipe without bricked status");

  // Bricked answers carry the all-ones delay
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_bricked_o |->
      delay_remaining_ms_o == prl_pkg::DelayAllOnes)
    else $error("bricked result without all-ones delay");

  // A wait carries a real, nonzero delay
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == prl_pkg::STATUS_WAIT) |->
      (delay_remaining_ms_o != '0) && !is_bricked_o &&
      (delay_remaining_ms_o != prl_pkg::DelayAllOnes))
    else $error("wait status with bad delay");

endmodule

bind pin_retry_lockout_limiter prl_checker u_prl_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_o          (out_valid_o),
  .out_ready_i          (out_ready_i),
  .status_o             (status_o),
  .delay_remaining_ms_o (delay_remaining_ms_o),
  .is_bricked_o         (is_bricked_o),
  .wipe_pulse_o         (wipe_pulse_o)
);

// ===== tb/tb_pin_retry_lockout_limiter.sv =====
`timescale 1ns / 1ps

module tb_pin_retry_lockout_limiter;

  localparam int unsigned CountW     = prl_pkg::CountW;
  localparam int unsigned TimeW      = prl_pkg::TimeW;
  localparam int unsigned DlW        = prl_pkg::DlW;
  localparam int unsigned DelayW     = prl_pkg::DelayW;
  localparam int unsigned CfgIdxW    = prl_pkg::CfgIdxW;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxReports = 40;
  localparam int unsigned PhaseItems = 190;
  localparam logic [1:0]  ReqUnused  = 2'd3;

  // One row of the directed table; want is used only when fixed is set
  typedef struct packed {
    logic [1:0]       req;
    logic [TimeW-1:0] now;
    logic             fixed;
    prl_pkg::result_t want;
  } pin_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [DelayW-1:0]   cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          req_type_i;
  logic [TimeW-1:0]    now_ms_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [1:0]          status_o;
  logic [CountW-1:0]   attempt_count_o;
  logic [DelayW-1:0]   delay_remaining_ms_o;
  logic                is_bricked_o;
  logic                wipe_pulse_o;

  // Predicted lockout state and register copies
  logic [CountW-1:0]   lk_count;
  logic [DlW-1:0]      lk_deadline;
  logic                lk_bricked;
  logic [CountW-1:0]   cfg_max_att;
  logic [DelayW-1:0]   cfg_tier1;
  logic [DelayW-1:0]   cfg_tier2;
  logic [DelayW-1:0]   cfg_tier3;

  prl_pkg::result_t    expected_q[$];
  pin_row_t            pin_rows[$];
  logic [TimeW-1:0]    clock_ms;
  int unsigned         mismatch_total = 0;
  int unsigned         cycle_cnt = 0;
  int                  rx_hold_cycles = 0;
  bit                  tx_idle = 1'b0;
  bit                  rx_idle = 1'b0;

  pin_retry_lockout_limiter uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .req_type_i           (req_type_i),
    .now_ms_i             (now_ms_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .status_o             (status_o),
    .attempt_count_o      (attempt_count_o),
    .delay_remaining_ms_o (delay_remaining_ms_o),
    .is_bricked_o         (is_bricked_o),
    .wipe_pulse_o         (wipe_pulse_o)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Lockout delay for a failure count
  function automatic logic [DelayW-1:0] tier_delay_ms(input logic [CountW-1:0] n);
    if (n <= prl_pkg::Tier0Last) return '0;
    if (n <= prl_pkg::Tier1Last) return cfg_tier1;
    if (n <= prl_pkg::Tier2Last) return cfg_tier2;
    if (int'(n) + 1 <= int'(cfg_max_att)) return cfg_tier3;
    return prl_pkg::DelayAllOnes;
  endfunction

  // Register write into the predicted copy
  function automatic void lockout_config(input prl_pkg::cfg_idx_e idx,
                                         input logic [DelayW-1:0] v);
    case (idx)
      prl_pkg::CFG_MAX_ATTEMPTS: begin
        cfg_max_att = (v[CountW-1:0] < prl_pkg::MaxAttMin) ? prl_pkg::MaxAttMin :
                      v[CountW-1:0];
      end
      prl_pkg::CFG_DELAY_TIER1: begin
        cfg_tier1 = (v == prl_pkg::DelayAllOnes) ? prl_pkg::DelayMax : v;
      end
      prl_pkg::CFG_DELAY_TIER2: begin
        cfg_tier2 = (v == prl_pkg::DelayAllOnes) ? prl_pkg::DelayMax : v;
      end
      default: begin
        cfg_tier3 = (v == prl_pkg::DelayAllOnes) ? prl_pkg::DelayMax : v;
      end
    endcase
  endfunction

  // Apply one request to the predicted state and return its result
  function automatic prl_pkg::result_t lockout_step(input logic [1:0] req,
                                                    input logic [TimeW-1:0] now);
    prl_pkg::result_t  r;
    logic [DelayW-1:0] d;
    logic [DlW-1:0]    diff;
    r = '0;
    if (req == prl_pkg::REQ_SUCCESS) begin
      lk_count = '0;
      lk_deadline = '0;
    end else if (req == prl_pkg::REQ_FAILURE) begin
      if (lk_count != prl_pkg::CountSat) lk_count = lk_count + 1'b1;
      if (lk_count >= cfg_max_att) begin
        lk_bricked = 1'b1;
        r.wipe = 1'b1;
      end else begin
        d = tier_delay_ms(lk_count);
        if (d != '0 && d != prl_pkg::DelayAllOnes) lk_deadline = DlW'(now) + DlW'(d);
        else lk_deadline = '0;
      end
    end
    r.count = lk_count;
    r.bricked = lk_bricked || (lk_count >= cfg_max_att);
    if (r.bricked) begin
      r.status = prl_pkg::STATUS_BRICKED;
      r.remaining = prl_pkg::DelayAllOnes;
    end else if (lk_deadline != '0 && DlW'(now) < lk_deadline) begin
      diff = lk_deadline - DlW'(now);
      r.status = prl_pkg::STATUS_WAIT;
      r.remaining = (diff > DlW'(prl_pkg::DelayMax)) ? prl_pkg::DelayMax :
                    diff[DelayW-1:0];
    end else begin
      r.status = prl_pkg::STATUS_ALLOWED;
      r.remaining = '0;
    end
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [DelayW-1:0] want,
                                      input logic [DelayW-1:0] got);
    if (got !== want) begin
      mismatch_total++;
      if (mismatch_total <= MaxReports)
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  // Result checker: compare every output transfer with the oldest prediction
  always @(posedge clk_i) begin : chk_result
    prl_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        mismatch_total++;
        if (mismatch_total <= MaxReports)
          $display("%0t ns: result with nothing pending, expected none, actual count %0d",
                   $time, attempt_count_o);
      end else begin
        want = expected_q.pop_front();
        check_field("status", DelayW'(want.status), DelayW'(status_o));
        check_field("attempt_count", DelayW'(want.count), DelayW'(attempt_count_o));
        check_field("delay_remaining_ms", want.remaining, delay_remaining_ms_o);
        check_field("is_bricked", DelayW'(want.bricked), DelayW'(is_bricked_o));
        check_field("wipe_pulse", DelayW'(want.wipe), DelayW'(wipe_pulse_o));
      end
    end
  end

  // Result side: random stalls, plus one long hold-off when asked
  initial begin
    int gap;
    out_ready_i <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (rx_hold_cycles != 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        gap = rx_idle ? $urandom_range(0, 14) : 0;
      end
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Offer one request, wait for its transfer, then record the prediction
  task automatic send_attempt(input logic [1:0] req, input logic [TimeW-1:0] now,
                              input bit fixed, input prl_pkg::result_t want);
    int               gap;
    prl_pkg::result_t exp_res;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    now_ms_i <= now;
    do @(posedge clk_i); while (!in_ready_o);
    exp_res = lockout_step(req, now);
    if (fixed) exp_res = want;
    expected_q.push_back(exp_res);
  endtask

  // Mostly monotonic time with failure streaks; some jumps anywhere in time
  task automatic send_random_attempt(input bit allow_brick);
    logic [1:0]       req;
    logic [TimeW-1:0] now;
    int               pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      case ($urandom_range(0, 4))
        0: ;
        1: clock_ms += TimeW'($urandom_range(0, 100));
        2: clock_ms += TimeW'($urandom_range(0, 20000));
        3: clock_ms += TimeW'($urandom_range(0, 1000000));
        default: clock_ms += TimeW'($urandom);
      endcase
      now = clock_ms;
    end else begin
      now = {16'($urandom), 32'($urandom)};
      if (pick < 92) clock_ms = now;
    end
    pick = $urandom_range(0, 99);
    if (pick < 50) req = prl_pkg::REQ_FAILURE;
    else if (pick < 86) req = prl_pkg::REQ_CHECK;
    else if (pick < 93) req = prl_pkg::REQ_SUCCESS;
    else req = ReqUnused;
    // bricking is permanent, so keep it for the last phase
    if (req == prl_pkg::REQ_FAILURE && !allow_brick &&
        int'(lk_count) + 1 >= int'(cfg_max_att))
      req = prl_pkg::REQ_SUCCESS;
    send_attempt(req, now, 1'b0, '0);
  endtask

  // Stop offering and let every pending result come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all four registers in index order; block must be idle
  task automatic apply_settings(input logic [DelayW-1:0] m, input logic [DelayW-1:0] t1,
                                input logic [DelayW-1:0] t2, input logic [DelayW-1:0] t3);
    logic [DelayW-1:0] vals [4];
    vals[0] = m;
    vals[1] = t1;
    vals[2] = t2;
    vals[3] = t3;
    cfg_we_i <= 1'b1;
    for (int k = 0; k < 4; k++) begin
      cfg_index_i <= CfgIdxW'(k);
      cfg_wdata_i <= vals[k];
      @(posedge clk_i);
      lockout_config(prl_pkg::cfg_idx_e'(k), vals[k]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_row(input logic [1:0] req, input logic [TimeW-1:0] now, input bit fixed,
                         input prl_pkg::status_e st, input logic [CountW-1:0] cnt,
                         input logic [DelayW-1:0] rem);
    pin_row_t row;
    row = '0;
    row.req = req;
    row.now = now;
    row.fixed = fixed;
    row.want.status = st;
    row.want.count = cnt;
    row.want.remaining = rem;
    pin_rows.push_back(row);
  endtask

  initial begin
    logic [DelayW-1:0] m, t1, t2, t3;
    pin_row_t          row;

    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    req_type_i <= '0;
    now_ms_i <= '0;
    lk_count = '0;
    lk_deadline = '0;
    lk_bricked = 1'b0;
    cfg_max_att = prl_pkg::MaxAttRst;
    cfg_tier1 = prl_pkg::Tier1Rst;
    cfg_tier2 = prl_pkg::Tier2Rst;
    cfg_tier3 = prl_pkg::Tier3Rst;
    clock_ms = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset settings: walk through every tier, then time going backwards
    add_row(prl_pkg::REQ_CHECK,   48'd0,              1, prl_pkg::STATUS_ALLOWED, 8'd0,
            32'd0);
    add_row(ReqUnused,            48'hFFFF_FFFF_FFFF, 1, prl_pkg::STATUS_ALLOWED, 8'd0,
            32'd0);
    add_row(prl_pkg::REQ_FAILURE, 48'd100,            1, prl_pkg::STATUS_ALLOWED, 8'd1,
            32'd0);
    add_row(prl_pkg::REQ_FAILURE, 48'd200,            1, prl_pkg::STATUS_ALLOWED, 8'd2,
            32'd0);
    add_row(prl_pkg::REQ_FAILURE, 48'd300,            1, prl_pkg::STATUS_ALLOWED, 8'd3,
            32'd0);
    add_row(prl_pkg::REQ_FAILURE, 48'd1000,           1, prl_pkg::STATUS_WAIT,    8'd4,
            32'd15000);
    add_row(prl_pkg::REQ_CHECK,   48'd15999,          1, prl_pkg::STATUS_WAIT,    8'd4,
            32'd1);
    add_row(prl_pkg::REQ_CHECK,   48'd16000,          1, prl_pkg::STATUS_ALLOWED, 8'd4,
            32'd0);
    add_row(prl_pkg::REQ_FAILURE, 48'd20000,          0, prl_pkg::STATUS_ALLOWED, 8'd0,
            32'd0);
    add_row(prl_pkg::REQ_FAILURE, 48'd40000,          0, prl_pkg::STATUS_ALLOWED, 8'd0,
            32'd0);
    add_row(prl_pkg::REQ_FAILURE, 48'd100000,         1, prl_pkg::STATUS_WAIT,    8'd7,
            32'd60000);
    add_row(prl_pkg::REQ_FAILURE, 48'd200000,         0, prl_pkg::STATUS_ALLOWED, 8'd0,
            32'd0);
    add_row(prl_pkg::REQ_FAILURE, 48'd300000,         0, prl_pkg::STATUS_ALLOWED, 8'd0,
            32'd0);
    add_row(prl_pkg::REQ_FAILURE, 48'd400000,         1, prl_pkg::STATUS_WAIT,    8'd10,
            32'd900000);
    add_row(prl_pkg::REQ_CHECK,   48'd1300000,        1, prl_pkg::STATUS_ALLOWED, 8'd10,
            32'd0);
    add_row(prl_pkg::REQ_FAILURE, 48'hFFFF_FFFF_FFFF, 1, prl_pkg::STATUS_WAIT,    8'd11,
            32'd900000);
    add_row(prl_pkg::REQ_CHECK,   48'd0,              1, prl_pkg::STATUS_WAIT,    8'd11,
            prl_pkg::DelayMax);
    add_row(ReqUnused,            48'd5,              0, prl_pkg::STATUS_ALLOWED, 8'd0,
            32'd0);
    add_row(prl_pkg::REQ_SUCCESS, 48'd0,              1, prl_pkg::STATUS_ALLOWED, 8'd0,
            32'd0);
    add_row(prl_pkg::REQ_CHECK,   48'hFFFF_FFFF_FFFF, 1, prl_pkg::STATUS_ALLOWED, 8'd0,
            32'd0);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    while (pin_rows.size() != 0) begin
      row = pin_rows.pop_front();
      send_attempt(row.req, row.now, row.fixed, row.want);
    end

    // Random phases over several register settings; phase 0 keeps reset values
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      case (ph)
        1: begin
          m = 32'd255;
          t1 = prl_pkg::DelayAllOnes;
          t2 = prl_pkg::DelayAllOnes;
          t3 = prl_pkg::DelayAllOnes;
        end
        2: begin m = 32'd0; t1 = '0; t2 = '0; t3 = '0; end
        3: begin m = 32'd12; t1 = 32'd1; t2 = 32'd2; t3 = 32'd3; end
        4: begin m = {24'hFF_FFFF, 8'd255}; t1 = '0; t2 = prl_pkg::DelayMax; t3 = 32'd1; end
        5: begin
          m = {24'($urandom), 8'($urandom_range(0, 255))};
          t1 = $urandom_range(0, 70000);
          t2 = $urandom_range(0, 70000);
          t3 = $urandom_range(0, 70000);
        end
        6: begin m = $urandom; t1 = $urandom; t2 = $urandom; t3 = $urandom; end
        7: begin
          m = 32'd21;
          t1 = prl_pkg::Tier1Rst;
          t2 = prl_pkg::Tier2Rst;
          t3 = prl_pkg::Tier3Rst;
        end
        default: ;
      endcase
      if (ph != 0) apply_settings(m, t1, t2, t3);
      tx_idle = $urandom_range(0, 2) != 0;
      rx_idle = $urandom_range(0, 2) != 0;
      if (ph == 0) begin
        // long receiver hold-off while requests keep coming back to back
        rx_hold_cycles = 300;
        tx_idle = 1'b0;
      end
      for (int i = 0; i < PhaseItems; i++) begin
        if (i == PhaseItems / 2) begin
          drain_results();
          tx_idle = $urandom_range(0, 1) != 0;
          rx_idle = $urandom_range(0, 1) != 0;
        end
        send_random_attempt(1'b0);
      end
    end

    // Lowered limit: build a count, then drop max_attempts below it
    drain_results();
    apply_settings(32'd200, prl_pkg::Tier1Rst, prl_pkg::Tier2Rst, prl_pkg::Tier3Rst);
    for (int i = 0; i < 12; i++) begin
      clock_ms += 48'd500;
      send_attempt(prl_pkg::REQ_FAILURE, clock_ms, 1'b0, '0);
    end
    drain_results();
    apply_settings(32'd5, prl_pkg::Tier1Rst, prl_pkg::Tier2Rst, prl_pkg::Tier3Rst);
    send_attempt(prl_pkg::REQ_CHECK, clock_ms, 1'b0, '0);
    send_attempt(ReqUnused, clock_ms + 48'd1, 1'b0, '0);
    send_attempt(prl_pkg::REQ_SUCCESS, clock_ms + 48'd2, 1'b0, '0);
    send_attempt(prl_pkg::REQ_CHECK, clock_ms + 48'd3, 1'b0, '0);

    // Bricking, repeated wipes, count saturation and success while bricked
    drain_results();
    apply_settings(32'd6, 32'd100, 32'd200, 32'd300);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (int i = 0; i < 30; i++) send_random_attempt(1'b1);
    for (int i = 0; i < 260; i++) begin
      clock_ms += TimeW'($urandom_range(0, 400));
      send_attempt(prl_pkg::REQ_FAILURE, clock_ms, 1'b0, '0);
    end
    for (int i = 0; i < 20; i++) send_random_attempt(1'b1);

    drain_results();
    if (mismatch_total == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
